// ===== rtl/protobuf_token_lexer_assert.svh =====
// ----------------------------------------------------------------------------
// protobuf_token_lexer_assert
// Assertion macros used by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_TOKEN_LEXER_ASSERT_SVH
`define PROTOBUF_TOKEN_LEXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");
`else
`define PTL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ptl_pkg.sv =====
// ----------------------------------------------------------------------------
// ptl_pkg
// Types, constants and character class helpers for the protobuf token lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package ptl_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int NWORDS = 27;
    localparam int RPC_INDEX = 11;
    localparam logic [NWORDS-1:0] KEYWORD_MASK = 27'h00007FF;
    localparam logic [NWORDS-1:0] TYPE_MASK = 27'h7FFF000;
    localparam logic [NWORDS-1:0] ALL_WORDS = 27'h7FFFFFF;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_NAME   = 4'd1,
        M_NUMBER = 4'd2,
        M_STRING = 4'd3,
        M_SLASH  = 4'd4,
        M_LINE   = 4'd5,
        M_BLOCK  = 4'd6,
        M_ANGLE  = 4'd7,
        M_OPER   = 4'd8
    } mode_t;

    typedef enum logic [3:0] {
        TT_DEFAULT = 4'd0,
        TT_KEYWORD = 4'd1,
        TT_TYPE    = 4'd2,
        TT_IDENT   = 4'd3,
        TT_NUMBER  = 4'd4,
        TT_STRING  = 4'd5,
        TT_OPEN    = 4'd6,
        TT_CLOSE   = 4'd7,
        TT_COMMENT = 4'd8,
        TT_PUNCT   = 4'd9
    } tok_t;

    // Word list, up to 8 bytes, first byte in the low byte.
    function automatic logic [63:0] word_text(input int k);
        logic [63:0] w;
        unique case (k)
            0: w = "mune";
            1: w = "egassem";
            2: w = "ralugnis";
            3: w = "lanoitpo";
            4: w = "detaeper";
            5: w = "pam";
            6: w = "eurt";
            7: w = "eslaf";
            8: w = "xatnys";
            9: w = "ecivres";
            10: w = "snruter";
            11: w = "cpr";
            12: w = "elbuod";
            13: w = "taolf";
            14: w = "23tni";
            15: w = "46tni";
            16: w = "23tniu";
            17: w = "46tniu";
            18: w = "23tnis";
            19: w = "46tnis";
            20: w = "23dexif";
            21: w = "46dexif";
            22: w = "23dexifs";
            23: w = "46dexifs";
            24: w = "loob";
            25: w = "gnirts";
            default: w = "setyb";
        endcase
        return w;
    endfunction

    function automatic logic [3:0] word_len(input int k);
        logic [3:0] l;
        unique case (k)
            0, 6, 24: l = 4'd4;
            1, 9, 10, 20, 21: l = 4'd7;
            2, 3, 4, 22, 23: l = 4'd8;
            5, 11: l = 4'd3;
            7, 13, 14, 15, 26: l = 4'd5;
            default: l = 4'd6;
        endcase
        return l;
    endfunction

    function automatic logic lower_letter(input logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7A;
    endfunction
    function automatic logic is_upper(input logic [7:0] c);
        return c >= 8'h41 && c <= 8'h5A;
    endfunction
    function automatic logic dec_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_name_start(input logic [7:0] c);
        return c == 8'h5F || lower_letter(c) || is_upper(c);
    endfunction
    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A
            || c == 8'h0B || c == 8'h0C;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/protobuf_token_lexer.sv =====
// Output: a result is registered in the output slots when its byte is taken.
// Throughput: one item per cycle while in_stall is low, which it is not while
// the output stalls with a result held; a byte that yields two tokens emits them
// one after the other, and the input stalls while the second token waits in its slot.
// Reset: rst_n is asynchronous active low; it returns the lexer to idle
// between tokens at position zero with no results pending.
// ----------------------------------------------------------------------------
// protobuf_token_lexer
// Byte-per-cycle lexer, held by in_stall, that classifies protobuf source into tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module protobuf_token_lexer
    import ptl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  ch,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       tok_class,
    output logic [31:0]      token_start,
    output logic [31:0]      token_end,
    output logic             last
);
`include "protobuf_token_lexer_assert.svh"

    localparam int PB = POSITION_BITS;

    // Lexer state.
    logic [PB-1:0]     pos_reg, spos_reg;
    mode_t             mode_reg;
    logic [7:0]        open_reg;
    logic [NWORDS-1:0] cand_reg;
    logic [3:0]        len_reg;
    logic [2:0]        flags_reg;
    logic              rpc_reg, esc_reg, ostage_reg;

    // Output: up to two results held; the second waits in a second slot.
    logic        o0_v_reg, o1_v_reg;
    logic [3:0]  o0_t_reg, o1_t_reg;
    logic [31:0] o0_s_reg, o0_e_reg, o1_s_reg, o1_e_reg;
    logic        o0_l_reg;

    logic take;
    // The lexer takes an item when both output slots will be free to receive.
    assign in_stall = o1_v_reg || (o0_v_reg && out_stall);
    assign take = in_valid && !in_stall;

    // Word matching. While a name is pending the same candidate mask and
    // length give both the match of the name so far and the update for the
    // incoming byte; a new name starts from the full mask.
    logic [NWORDS-1:0] cand_src, cand_upd, hit;
    logic [3:0]        len_src;
    logic              fresh;
    assign fresh = (mode_reg != M_NAME);
    assign cand_src = fresh ? ALL_WORDS : cand_reg;
    assign len_src = fresh ? 4'd0 : len_reg;

    ptl_words u_words (
        .cand     (cand_src),
        .len      (len_src),
        .ch       (ch),
        .cand_upd (cand_upd),
        .hit      (hit)
    );

    // Combinational step.
    logic [PB-1:0]     pos_next, spos_next, nxt;
    mode_t             mode_next;
    logic [7:0]        open_next;
    logic [NWORDS-1:0] cand_next;
    logic [3:0]        len_next;
    logic [2:0]        flags_next;
    logic              rpc_next, esc_next, ostage_next;
    logic [1:0]        n;
    logic [3:0]        t0, t1;
    logic [31:0]       s0, e0, s1, e1;

    always_comb
    begin
        logic        fin, taken, fin_rpc, is_rpc_hit;
        logic [3:0]  ft, nt;
        logic [PB-1:0] fend, cur;
        logic        do_begin, is_op4;

        pos_next = pos_reg; spos_next = spos_reg; mode_next = mode_reg;
        open_next = open_reg; cand_next = cand_reg; len_next = len_reg;
        flags_next = flags_reg; rpc_next = rpc_reg; esc_next = esc_reg;
        ostage_next = ostage_reg;
        n = 2'd0; t0 = 4'd0; t1 = 4'd0; s0 = '0; e0 = '0; s1 = '0; e1 = '0;
        cur = pos_reg;
        nxt = pos_reg + 1'b1;
        fin = 1'b0; taken = 1'b0; fend = cur; do_begin = 1'b0;
        nt = 4'hF;
        is_rpc_hit = hit[RPC_INDEX];
        is_op4 = open_reg == 8'h2B || open_reg == 8'h2D
            || open_reg == 8'h7C || open_reg == 8'h26;

        // Type of the pending token.
        fin_rpc = 1'b0;
        unique case (mode_reg)
            M_NAME:
            begin
                if (is_rpc_hit)
                begin
                    ft = TT_KEYWORD; fin_rpc = 1'b1;
                end
                else if ((hit & KEYWORD_MASK) != '0) ft = TT_KEYWORD;
                else if ((hit & TYPE_MASK) != '0) ft = TT_TYPE;
                else if (!rpc_reg && flags_reg == 3'b100) ft = TT_TYPE;
                else ft = TT_IDENT;
            end
            M_NUMBER: ft = TT_NUMBER;
            M_STRING: ft = TT_STRING;
            M_LINE, M_BLOCK: ft = TT_COMMENT;
            default: ft = TT_PUNCT;
        endcase

        if (kind)
        begin
            fin = (mode_reg != M_IDLE);
            fend = cur;
        end
        else
        begin
            unique case (mode_reg)
                M_NAME:
                    if (is_name_start(ch) || dec_digit(ch)) taken = 1'b1;
                    else fin = 1'b1;
                M_NUMBER:
                    if (is_name_start(ch) && ch != 8'h5F || dec_digit(ch))
                        taken = 1'b1;
                    else fin = 1'b1;
                M_STRING:
                begin
                    taken = 1'b1;
                    if (esc_reg) esc_next = 1'b0;
                    else if (ch == open_reg)
                    begin
                        fin = 1'b1; fend = nxt;
                    end
                    else if (ch == 8'h5C) esc_next = 1'b1;
                end
                M_SLASH:
                    if (ch == 8'h2F)
                    begin
                        taken = 1'b1; mode_next = M_LINE;
                    end
                    else if (ch == 8'h2A)
                    begin
                        taken = 1'b1; mode_next = M_BLOCK; esc_next = 1'b0;
                    end
                    else if (ch == 8'h3D)
                    begin
                        taken = 1'b1; fin = 1'b1; fend = nxt;
                    end
                    else fin = 1'b1;
                M_LINE:
                    if (ch != 8'h0A) taken = 1'b1;
                    else fin = 1'b1;
                M_BLOCK:
                begin
                    taken = 1'b1;
                    if (esc_reg && ch == 8'h2F)
                    begin
                        fin = 1'b1; fend = nxt;
                    end
                    else esc_next = (ch == 8'h2A);
                end
                M_ANGLE:
                    if (!ostage_reg && ch == open_reg)
                    begin
                        taken = 1'b1; ostage_next = 1'b1;
                    end
                    else if (ch == 8'h3D)
                    begin
                        taken = 1'b1; fin = 1'b1; fend = nxt;
                    end
                    else fin = 1'b1;
                M_OPER:
                    if (ch == 8'h3D || (is_op4 && ch == open_reg))
                    begin
                        taken = 1'b1; fin = 1'b1; fend = nxt;
                    end
                    else fin = 1'b1;
                default: ;
            endcase
            do_begin = !taken;
        end

        if (fin)
        begin
            n = 2'd1; t0 = ft;
            s0 = 32'(spos_reg); e0 = 32'(fend);
            rpc_next = fin_rpc;
            mode_next = M_IDLE;
        end

        if (!kind && taken && mode_reg == M_NAME)
        begin
            cand_next = cand_upd;
            if (len_reg != 4'd15) len_next = len_reg + 1'b1;
            if (ch == 8'h5F) flags_next[1] = 1'b1;
            if (lower_letter(ch)) flags_next[2] = 1'b1;
        end

        if (do_begin && !is_space(ch))
        begin
            spos_next = cur;
            if (is_name_start(ch))
            begin
                mode_next = M_NAME;
                cand_next = cand_upd;
                len_next = 4'd1;
                flags_next = {lower_letter(ch), ch == 8'h5F, lower_letter(ch)};
            end
            else if (dec_digit(ch)) mode_next = M_NUMBER;
            else if (ch == 8'h22 || ch == 8'h27)
            begin
                mode_next = M_STRING; open_next = ch; esc_next = 1'b0;
            end
            else if (ch == 8'h7B || ch == 8'h5B || ch == 8'h28) nt = TT_OPEN;
            else if (ch == 8'h7D || ch == 8'h5D || ch == 8'h29) nt = TT_CLOSE;
            else if (ch == 8'h2F) mode_next = M_SLASH;
            else if (ch == 8'h3C || ch == 8'h3E)
            begin
                mode_next = M_ANGLE; open_next = ch; ostage_next = 1'b0;
            end
            else if (ch == 8'h3A || ch == 8'h3D || ch == 8'h21 || ch == 8'h2B
                || ch == 8'h2D || ch == 8'h2A || ch == 8'h25 || ch == 8'h5E
                || ch == 8'h7C || ch == 8'h26)
            begin
                mode_next = M_OPER; open_next = ch;
            end
            else if (ch == 8'h3B || ch == 8'h2C || ch == 8'h2E) nt = TT_PUNCT;
            else nt = TT_DEFAULT;
            if (nt != 4'hF)
            begin
                rpc_next = 1'b0;
                if (fin)
                begin
                    n = 2'd2; t1 = nt; s1 = 32'(cur); e1 = 32'(nxt);
                end
                else
                begin
                    n = 2'd1; t0 = nt; s0 = 32'(cur); e0 = 32'(nxt);
                end
            end
        end

        if (kind)
        begin
            pos_next = '0; spos_next = '0; open_next = 8'h00;
            cand_next = ALL_WORDS; len_next = 4'd0; flags_next = 3'b000;
            esc_next = 1'b0; ostage_next = 1'b0; mode_next = M_IDLE;
        end
        else pos_next = nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; spos_reg <= '0; mode_reg <= M_IDLE; open_reg <= 8'h00;
            cand_reg <= ALL_WORDS; len_reg <= 4'd0; flags_reg <= 3'b000;
            rpc_reg <= 1'b0; esc_reg <= 1'b0; ostage_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg <= pos_next; spos_reg <= spos_next; mode_reg <= mode_next;
            open_reg <= open_next; cand_reg <= cand_next; len_reg <= len_next;
            flags_reg <= flags_next; rpc_reg <= rpc_next; esc_reg <= esc_next;
            ostage_reg <= ostage_next;
        end
    end

    // Output slots: slot 0 faces the port, slot 1 holds a second token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o0_v_reg <= 1'b0; o1_v_reg <= 1'b0;
        end
        else if (take)
        begin
            o0_v_reg <= (n != 2'd0);
            o1_v_reg <= (n == 2'd2);
        end
        else if (o0_v_reg && !out_stall)
        begin
            o0_v_reg <= o1_v_reg;
            o1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            o0_t_reg <= t0; o0_s_reg <= s0; o0_e_reg <= e0;
            o0_l_reg <= (n == 2'd1);
            o1_t_reg <= t1; o1_s_reg <= s1; o1_e_reg <= e1;
        end
        else if (o0_v_reg && !out_stall)
        begin
            o0_t_reg <= o1_t_reg; o0_s_reg <= o1_s_reg; o0_e_reg <= o1_e_reg;
            o0_l_reg <= 1'b1;
        end
    end

    assign out_valid = o0_v_reg;
    assign tok_class = o0_t_reg;
    assign token_start = o0_s_reg;
    assign token_end = o0_e_reg;
    assign last = o0_l_reg;

    `PTL_ASSERT_IMPL(a_slot_order, clk, rst_n, o1_v_reg, o0_v_reg)
    `PTL_ASSERT_IMPL(a_first_not_last, clk, rst_n, o1_v_reg, !o0_l_reg)
    `PTL_ASSERT_NEXT(a_flush_idle, clk, rst_n, take && kind, mode_reg == M_IDLE && pos_reg == '0)
    `PTL_ASSERT_IMPL(a_no_take_full, clk, rst_n, o1_v_reg, !take)
endmodule
`default_nettype wire

// ===== rtl/ptl_words.sv =====
// ----------------------------------------------------------------------------
// ptl_words
// Keyword candidate mask update and the hit mask for keyword or type classification.
// ----------------------------------------------------------------------------
`default_nettype none
module ptl_words
    import ptl_pkg::*;
(
    input  wire logic [NWORDS-1:0] cand,
    input  wire logic [3:0]        len,
    input  wire logic [7:0]        ch,
    output logic      [NWORDS-1:0] cand_upd,
    output logic      [NWORDS-1:0] hit
);
    always_comb
    begin
        logic [63:0] w;
        for (int k = 0; k < NWORDS; k++)
        begin
            w = word_text(k);
            cand_upd[k] = cand[k] && (len < word_len(k))
                && (w[len[2:0]*8 +: 8] == ch);
            hit[k] = cand[k] && (word_len(k) == len);
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the protobuf token lexer. A behavioral token model
// predicts every token from the bytes that are accepted, and a monitor checks
// each accepted token against the oldest prediction. Both sides of the
// handshake stall in random bursts, except in the closing part of the run.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top
    import ptl_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic [3:0]  tt;
        logic [31:0] first;
        logic [31:0] past;
        logic        fin;
    } token_rec_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  tok_class;
    logic [31:0] token_start;
    logic [31:0] token_end;
    logic        last;

    protobuf_token_lexer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tok_class   (tok_class),
        .token_start (token_start),
        .token_end   (token_end),
        .last        (last)
    );

    // Tokens predicted but not yet seen at the output, oldest first.
    token_rec_t pending_tokens[$];
    int         mismatches;
    int         cycle_count;
    int         stall_left;
    bit         quiet;

    // The 27 words tracked by the candidate mask, in mask bit order.
    string lex_words[NWORDS] = '{
        "enum", "message", "singular", "optional", "repeated", "map", "true",
        "false", "syntax", "service", "returns", "rpc",
        "double", "float", "int32", "int64", "uint32", "uint64", "sint32",
        "sint64", "fixed32", "fixed64", "sfixed32", "sfixed64", "bool",
        "string", "bytes"};

    // Shadow copy of the lexer state.
    logic [31:0]       lx_pos;
    logic [31:0]       lx_start;
    mode_t             lx_mode;
    logic [7:0]        lx_open;
    logic [NWORDS-1:0] lx_cand;
    logic [3:0]        lx_wlen;
    logic [2:0]        lx_flags;   // bit 2 lowercase, bit 1 underscore, bit 0 first lowercase
    logic              lx_rpc;
    logic              lx_esc;
    logic              lx_stage;
    int                step_tokens;

    // ------------------------------------------------------------------
    // Token model
    // ------------------------------------------------------------------
    function automatic bit chr_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction
    function automatic bit chr_alpha(logic [7:0] c);
        return chr_lower(c) || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit chr_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit chr_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void push_token(tok_t tt, logic [31:0] past, bit is_rpc);
        token_rec_t r;
        if (step_tokens >= 2)
            return;
        r.tt = tt;
        r.first = lx_start;
        r.past = past;
        r.fin = 1'b0;
        pending_tokens.push_back(r);
        step_tokens++;
        lx_rpc = is_rpc;
    endfunction

    function automatic void name_char(logic [7:0] c);
        for (int k = 0; k < NWORDS; k++)
            if (lx_wlen >= lex_words[k].len() || lex_words[k][lx_wlen] != c)
                lx_cand[k] = 1'b0;
        if (lx_wlen != 4'd15)
            lx_wlen++;
        if (c == "_")
            lx_flags[1] = 1'b1;
        if (chr_lower(c))
            lx_flags[2] = 1'b1;
    endfunction

    function automatic void close_name(logic [31:0] past);
        logic [NWORDS-1:0] hit;
        hit = '0;
        for (int k = 0; k < NWORDS; k++)
            if (lx_cand[k] && lex_words[k].len() == lx_wlen)
                hit[k] = 1'b1;
        if (hit[RPC_INDEX])
            push_token(TT_KEYWORD, past, 1'b1);
        else if ((hit & KEYWORD_MASK) != '0)
            push_token(TT_KEYWORD, past, 1'b0);
        else if ((hit & TYPE_MASK) != '0)
            push_token(TT_TYPE, past, 1'b0);
        else if (!lx_rpc && lx_flags == 3'b100)
            push_token(TT_TYPE, past, 1'b0);
        else
            push_token(TT_IDENT, past, 1'b0);
    endfunction

    function automatic void close_token(logic [31:0] past);
        case (lx_mode)
            M_NAME:                  close_name(past);
            M_NUMBER:                push_token(TT_NUMBER, past, 1'b0);
            M_STRING:                push_token(TT_STRING, past, 1'b0);
            M_LINE, M_BLOCK:         push_token(TT_COMMENT, past, 1'b0);
            M_SLASH, M_ANGLE, M_OPER: push_token(TT_PUNCT, past, 1'b0);
            default: ;
        endcase
        lx_mode = M_IDLE;
    endfunction

    // Starts a new token with a byte that the pending token did not take.
    function automatic void open_token(logic [7:0] c);
        logic [31:0] nxt;
        nxt = lx_pos + 1;
        if (chr_blank(c))
            return;
        lx_start = lx_pos;
        if (c == "_" || chr_alpha(c))
        begin
            lx_mode = M_NAME;
            lx_cand = ALL_WORDS;
            lx_wlen = '0;
            lx_flags = {2'b00, chr_lower(c)};
            name_char(c);
        end
        else if (chr_digit(c))
        begin
            lx_mode = M_NUMBER;
        end
        else if (c == "\"" || c == "'")
        begin
            lx_mode = M_STRING;
            lx_open = c;
            lx_esc = 1'b0;
        end
        else if (c == "{" || c == "[" || c == "(")
        begin
            push_token(TT_OPEN, nxt, 1'b0);
        end
        else if (c == "}" || c == "]" || c == ")")
        begin
            push_token(TT_CLOSE, nxt, 1'b0);
        end
        else if (c == "/")
        begin
            lx_mode = M_SLASH;
        end
        else if (c == "<" || c == ">")
        begin
            lx_mode = M_ANGLE;
            lx_open = c;
            lx_stage = 1'b0;
        end
        else if (c == ":" || c == "=" || c == "!" || c == "+" || c == "-" ||
                 c == "*" || c == "%" || c == "^" || c == "|" || c == "&")
        begin
            lx_mode = M_OPER;
            lx_open = c;
        end
        else if (c == ";" || c == "," || c == ".")
        begin
            push_token(TT_PUNCT, nxt, 1'b0);
        end
        else
        begin
            push_token(TT_DEFAULT, nxt, 1'b0);
        end
    endfunction

    // Offers a byte to the pending token; returns 1 when the token took it.
    function automatic bit grow_token(logic [7:0] c);
        logic [31:0] nxt;
        nxt = lx_pos + 1;
        case (lx_mode)
            M_NAME:
                if (c == "_" || chr_alpha(c) || chr_digit(c))
                begin
                    name_char(c);
                    return 1'b1;
                end
            M_NUMBER:
                if (chr_alpha(c) || chr_digit(c))
                    return 1'b1;
            M_STRING:
            begin
                if (lx_esc)
                begin
                    lx_esc = 1'b0;
                    return 1'b1;
                end
                if (c == lx_open)
                    close_token(nxt);
                else if (c == "\\")
                    lx_esc = 1'b1;
                return 1'b1;
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    lx_mode = M_LINE;
                    return 1'b1;
                end
                if (c == "*")
                begin
                    lx_mode = M_BLOCK;
                    lx_esc = 1'b0;
                    return 1'b1;
                end
                if (c == "=")
                begin
                    close_token(nxt);
                    return 1'b1;
                end
            end
            M_LINE:
                if (c != 8'h0A)
                    return 1'b1;
            M_BLOCK:
            begin
                // The star that opened the comment cannot close it.
                if (lx_esc && c == "/")
                    close_token(nxt);
                else
                    lx_esc = (c == "*");
                return 1'b1;
            end
            M_ANGLE:
            begin
                if (!lx_stage && c == lx_open)
                begin
                    lx_stage = 1'b1;
                    return 1'b1;
                end
                if (c == "=")
                begin
                    close_token(nxt);
                    return 1'b1;
                end
            end
            M_OPER:
                if (c == "=" || (c == lx_open && (c == "+" || c == "-" ||
                                                  c == "|" || c == "&")))
                begin
                    close_token(nxt);
                    return 1'b1;
                end
            default:
                return 1'b0;
        endcase
        close_token(lx_pos);
        return 1'b0;
    endfunction

    function automatic void lexer_reset();
        lx_pos = '0;
        lx_start = '0;
        lx_mode = M_IDLE;
        lx_open = '0;
        lx_cand = ALL_WORDS;
        lx_wlen = '0;
        lx_flags = '0;
        lx_rpc = 1'b0;
        lx_esc = 1'b0;
        lx_stage = 1'b0;
    endfunction

    // Predicts the tokens caused by one accepted transaction.
    function automatic void lexer_step(logic k, logic [7:0] c);
        step_tokens = 0;
        if (k == KIND_FLUSH)
        begin
            close_token(lx_pos);
            lx_pos = '0;
            lx_start = '0;
            lx_open = '0;
            lx_cand = ALL_WORDS;
            lx_wlen = '0;
            lx_flags = '0;
            lx_esc = 1'b0;
            lx_stage = 1'b0;
        end
        else
        begin
            if (!grow_token(c))
                open_token(c);
            lx_pos = lx_pos + 1;
        end
        if (step_tokens > 0)
            pending_tokens[$].fin = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock, stall generator, monitor and watchdog
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // The receiver stalls in random bursts while idling is allowed.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        token_rec_t exp_tok;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected token type=%0d start=%0d end=%0d last=%0b",
                             tok_class, token_start, token_end, last);
            end
            else
            begin
                exp_tok = pending_tokens.pop_front();
                if (tok_class !== exp_tok.tt || token_start !== exp_tok.first ||
                    token_end !== exp_tok.past || last !== exp_tok.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: token exp type=%0d start=%0d end=%0d last=%0b,",
                                  " got type=%0d start=%0d end=%0d last=%0b"},
                                 exp_tok.tt, exp_tok.first, exp_tok.past, exp_tok.fin,
                                 tok_class, token_start, token_end, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Sends one transaction and updates the prediction when it is accepted.
    // The sender may first go idle for a random burst.
    task automatic send_item(logic k, logic [7:0] c);
        if (!quiet && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        ch <= c;
        do
            @(posedge clk);
        while (in_stall);
        lexer_step(k, c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(KIND_BYTE, s[i]);
    endtask

    task automatic send_flush();
        send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // Byte extremes, a flush with nothing pending, and rpc followed by a
    // capitalized name, which must not become a type.
    task automatic test_extremes();
        send_flush();
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_text("rpc Ab(Cd)");
        send_flush();
    endtask

    // A byte that closes a token and also forms a one-byte token, strings
    // with escapes, and a block comment whose opening star is not a closer.
    task automatic test_lookahead();
        send_text("x;'a\\''/*/ */7e{");
        send_flush();
    endtask

    // Operators of every length, a line comment ended by LF, and a lone
    // slash and an unterminated string cut off by the flush.
    task automatic test_operators();
        send_text("<<=>>+++|&&!=//c\n/");
        send_flush();
        send_text("\"ab");
        send_flush();
    endtask

    // The sender holds off until every predicted token has come out.
    task automatic test_drain_pause();
        send_text("Foo_bar");
        in_valid <= 1'b0;
        wait (pending_tokens.size() == 0);
        @(posedge clk);
        send_flush();
    endtask

    task automatic send_random_snippet();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1, 2: send_text(lex_words[$urandom_range(0, NWORDS - 1)]);
            3: send_text("Msg");
            4: send_text("rpc Get (Req) returns (Rsp);");
            5: send_text("x_1 = 42;");
            6: send_text("\"s\\\"q\"");
            7: send_text("// note\n");
            8: send_text("/* a * b **/");
            9: send_text("a += b && c || d;");
            10: send_text("<=>><<");
            11: send_text("'q'[0]");
            12: send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
            13: send_flush();
            default: send_item(KIND_BYTE, 8'h20);
        endcase
        if ($urandom_range(0, 1) == 0)
            send_item(KIND_BYTE, 8'h20);
    endtask

    task automatic test_random(int n_snippets);
        repeat (n_snippets) send_random_snippet();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_BYTE;
        ch <= 8'h00;
        stall_left = 0;
        mismatches = 0;
        cycle_count = 0;
        quiet = 1'b0;
        lexer_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_lookahead();
        test_operators();
        test_drain_pause();
        test_random(110);
        quiet = 1'b1;
        test_random(17);
        send_flush();

        in_valid <= 1'b0;
        wait (pending_tokens.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
